[src/hswt_pkg.sv]
// ----------------------------------------------------------------------------
// hswt_pkg
// Shared constants, types and helpers for the Haar SWT multiscale product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hswt_pkg;

	localparam int BUFFER_DEPTH = 2048;
	localparam int MAX_LEVELS   = 3;
	localparam int SAMPLE_BITS  = 16;

	localparam int SAMPLE_W  = 16;
	localparam int RES_W     = 52;
	localparam int AW        = $clog2(BUFFER_DEPTH + 1) - 1;
	localparam int BUF_WORDS = 2 ** AW;
	localparam int IDX_W     = $clog2(AW);
	localparam int LVL_W     = $clog2(MAX_LEVELS + 1);
	localparam int APPROX_W  = SAMPLE_BITS + MAX_LEVELS;
	localparam int PROD_W    = SAMPLE_BITS * MAX_LEVELS + (MAX_LEVELS * (MAX_LEVELS + 1)) / 2;

	localparam logic [AW-1:0] BLOCK_LIMIT = AW'(BUF_WORDS - 1);

	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	typedef struct packed {
		logic          vld;
		logic          first;
		logic          dst_b;
		logic          pad_x;
		logic          pad_y;
		logic [AW-1:0] pos;
	} iss_t;

	typedef struct packed {
		logic                       en;
		logic                       bank;
		logic [AW-1:0]              addr;
		logic signed [APPROX_W-1:0] data;
	} awr_t;

	typedef struct packed {
		logic                     en;
		logic [AW-1:0]            addr;
		logic signed [PROD_W-1:0] data;
	} pwr_t;

	function automatic logic [IDX_W-1:0] msb_idx(input logic [AW-1:0] n);
		logic [IDX_W-1:0] j;
		j = '0;
		for (int i = 0; i < AW; i++) begin
			if (n[i])
				j = IDX_W'(i);
		end
		return j;
	endfunction

endpackage

[src/haar_swt_multiscale_product.sv]
// ----------------------------------------------------------------------------
// haar_swt_multiscale_product
// Undecimated Haar transform over a loaded block, multiscale detail product.
// Push: one word per cycle while idle, no fetch pending or unread. Closing
// push starts L passes over NU words each (NU = 2^(floor(log2 N)+1), L up
// to 3), one buffer word per cycle, set by the two-port approximation banks;
// input is held off meanwhile. Fetch: result word registered, no new fetch
// while one pends. Reset clears control state only; memories hold garbage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haar_swt_multiscale_product (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              op,
	input  logic signed [hswt_pkg::SAMPLE_W-1:0] sample,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hswt_pkg::RES_W-1:0]        product,
	output logic                              last_res,
	output logic                              empty_res
);
	import hswt_pkg::*;

	state_t               state_q;
	logic [AW-1:0]        count_q, rp_q, mask_q, o_q;
	logic [LVL_W-1:0]     levels_q, lvl_q;
	logic                 ready_q;
	logic                 fetch_pend_q, pend_empty_q, pend_one_q, pend_last_q;
	logic                 out_valid_q, last_res_q, empty_res_q;
	logic [RES_W-1:0]     product_q;

	logic                 acc, acc_push, acc_fetch;
	logic [AW-1:0]        n_base, n_new, ya, stride;
	logic                 wr_push, fetch_is_last;
	logic [IDX_W-1:0]     j;
	logic [AW:0]          nu;
	logic [LVL_W-1:0]     lv_new;
	logic                 alu_busy;

	iss_t                 iss;
	awr_t                 awr_alu, awr;
	pwr_t                 pwr;
	logic signed [APPROX_W-1:0] x, y;
	logic signed [PROD_W-1:0]   prod_rd;

	assign in_ready  = (state_q == ST_IDLE) && !fetch_pend_q && (!out_valid_q || out_ready);
	assign acc       = in_valid && in_ready;
	assign acc_push  = acc && (op == OP_PUSH);
	assign acc_fetch = acc && (op == OP_FETCH);

	always_comb begin
		n_base  = ready_q ? '0 : count_q;
		wr_push = n_base < BLOCK_LIMIT;
		n_new   = wr_push ? n_base + AW'(1) : n_base;
		j       = msb_idx(n_new);
		nu      = (AW + 1)'(2) << j;
		lv_new  = (j < IDX_W'(MAX_LEVELS)) ? LVL_W'(j) : LVL_W'(MAX_LEVELS);
		fetch_is_last = ({1'b0, rp_q} + (AW + 1)'(1)) >= {1'b0, count_q};
		stride  = AW'(1) << (lvl_q - LVL_W'(1));
		ya      = (o_q + stride) & mask_q;
	end

	always_comb begin
		iss.vld   = (state_q == ST_RUN);
		iss.first = (lvl_q == LVL_W'(1));
		iss.dst_b = lvl_q[0];
		iss.pad_x = iss.first && (o_q >= count_q);
		iss.pad_y = iss.first && (ya >= count_q);
		iss.pos   = o_q;
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			awr.en   = acc_push && wr_push;
			awr.bank = 1'b0;
			awr.addr = n_base;
			awr.data = APPROX_W'(sample);
		end else begin
			awr = awr_alu;
		end
	end

	hswt_approx_mem u_amem (
		.clk    (clk),
		.src_b  (~lvl_q[0]),
		.addr_x (o_q),
		.addr_y (ya),
		.wr     (awr),
		.x      (x),
		.y      (y)
	);

	hswt_prod_mem u_pmem (
		.clk     (clk),
		.rd_addr ((state_q == ST_IDLE) ? rp_q : o_q),
		.wr      (pwr),
		.rd_data (prod_rd)
	);

	hswt_lvl_alu u_alu (
		.clk     (clk),
		.arst_n  (arst_n),
		.iss     (iss),
		.x       (x),
		.y       (y),
		.prod_rd (prod_rd),
		.awr     (awr_alu),
		.pwr     (pwr),
		.busy    (alu_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rp_q         <= '0;
			ready_q      <= 1'b0;
			mask_q       <= '0;
			o_q          <= '0;
			levels_q     <= '0;
			lvl_q        <= LVL_W'(1);
			fetch_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			fetch_pend_q <= acc_fetch;
			if (fetch_pend_q)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (acc_push) begin
						count_q <= n_new;
						rp_q    <= '0;
						ready_q <= last;
						if (last) begin
							mask_q   <= nu[AW-1:0] - AW'(1);
							levels_q <= lv_new;
							lvl_q    <= LVL_W'(1);
							o_q      <= '0;
							if (lv_new != '0)
								state_q <= ST_RUN;
						end
					end else if (acc_fetch && ready_q) begin
						if (fetch_is_last) begin
							ready_q <= 1'b0;
							count_q <= '0;
							rp_q    <= '0;
						end else begin
							rp_q <= rp_q + AW'(1);
						end
					end
				end
				ST_RUN: begin
					if (o_q == mask_q)
						state_q <= ST_DRAIN;
					else
						o_q <= o_q + AW'(1);
				end
				ST_DRAIN: begin
					if (!alu_busy) begin
						o_q <= '0;
						if (lvl_q == levels_q) begin
							state_q <= ST_IDLE;
						end else begin
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= ST_RUN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_fetch) begin
			pend_empty_q <= !ready_q;
			pend_one_q   <= (levels_q == '0);
			pend_last_q  <= ready_q && fetch_is_last;
		end
		if (fetch_pend_q) begin
			empty_res_q <= pend_empty_q;
			last_res_q  <= pend_last_q;
			if (pend_empty_q)
				product_q <= '0;
			else if (pend_one_q)
				product_q <= RES_W'(1);
			else if (prod_rd[PROD_W-1])
				product_q <= '0;
			else
				product_q <= prod_rd[RES_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;
	assign last_res  = last_res_q;
	assign empty_res = empty_res_q;

`ifndef SYNTHESIS
	a_fetch_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fetch_pend_q |=> out_valid_q)
		else $error("fetch result not presented");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_res_q) |-> (product_q == '0 && !last_res_q))
		else $error("empty result carries data");

	a_no_fetch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !fetch_pend_q)
		else $error("fetch pending during level pass");

	a_run_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ready_q)
		else $error("level pass without a closed block");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_IDLE) |-> !alu_busy)
		else $error("level pipeline active while idle");
`endif

endmodule

[src/hswt_approx_mem.sv]
// ----------------------------------------------------------------------------
// hswt_approx_mem
// Ping-pong approximation banks, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hswt_approx_mem (
	input  logic                                clk,
	input  logic                                src_b,
	input  logic [hswt_pkg::AW-1:0]             addr_x,
	input  logic [hswt_pkg::AW-1:0]             addr_y,
	input  hswt_pkg::awr_t                      wr,
	output logic signed [hswt_pkg::APPROX_W-1:0] x,
	output logic signed [hswt_pkg::APPROX_W-1:0] y
);
	import hswt_pkg::*;

	logic signed [APPROX_W-1:0] mem_a [BUF_WORDS];
	logic signed [APPROX_W-1:0] mem_b [BUF_WORDS];
	logic signed [APPROX_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic                       sel_q;

	always_ff @(posedge clk) begin
		if (wr.en && !wr.bank)
			mem_a[wr.addr] <= wr.data;
		if (wr.en && wr.bank)
			mem_b[wr.addr] <= wr.data;
		ax_q  <= mem_a[addr_x];
		ay_q  <= mem_a[addr_y];
		bx_q  <= mem_b[addr_x];
		by_q  <= mem_b[addr_y];
		sel_q <= src_b;
	end

	assign x = sel_q ? bx_q : ax_q;
	assign y = sel_q ? by_q : ay_q;

endmodule

[src/hswt_prod_mem.sv]
// ----------------------------------------------------------------------------
// hswt_prod_mem
// Per-position running product store, one write and one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hswt_prod_mem (
	input  logic                                 clk,
	input  logic [hswt_pkg::AW-1:0]              rd_addr,
	input  hswt_pkg::pwr_t                       wr,
	output logic signed [hswt_pkg::PROD_W-1:0]   rd_data
);
	import hswt_pkg::*;

	logic signed [PROD_W-1:0] mem [BUF_WORDS];

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
		rd_data <= mem[rd_addr];
	end

endmodule

[src/hswt_lvl_alu.sv]
// ----------------------------------------------------------------------------
// hswt_lvl_alu
// One Haar level step: sum and difference, then product update pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hswt_lvl_alu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hswt_pkg::iss_t                       iss,
	input  logic signed [hswt_pkg::APPROX_W-1:0] x,
	input  logic signed [hswt_pkg::APPROX_W-1:0] y,
	input  logic signed [hswt_pkg::PROD_W-1:0]   prod_rd,
	output hswt_pkg::awr_t                       awr,
	output hswt_pkg::pwr_t                       pwr,
	output logic                                 busy
);
	import hswt_pkg::*;

	iss_t                       iss_s1;
	logic signed [APPROX_W-1:0] xv, yv, sum, diff;
	logic signed [PROD_W-1:0]   old;
	logic                       vld_s2, vld_s3;
	logic [AW-1:0]              pos_s2, pos_s3;
	logic signed [APPROX_W-1:0] diff_s2;
	logic signed [PROD_W-1:0]   old_s2, prod_s3;
	logic signed [PROD_W+APPROX_W-1:0] mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			iss_s1 <= iss;
			vld_s2 <= iss_s1.vld;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		pos_s2  <= iss_s1.pos;
		diff_s2 <= diff;
		old_s2  <= old;
		pos_s3  <= pos_s2;
		prod_s3 <= mul[PROD_W-1:0];
	end

	always_comb begin
		xv   = iss_s1.pad_x ? '0 : x;
		yv   = iss_s1.pad_y ? '0 : y;
		sum  = xv + yv;
		diff = xv - yv;
		old  = iss_s1.first ? PROD_W'(1) : prod_rd;
	end

	assign mul = old_s2 * diff_s2;

	assign awr.en   = iss_s1.vld;
	assign awr.bank = iss_s1.dst_b;
	assign awr.addr = iss_s1.pos;
	assign awr.data = sum;

	assign pwr.en   = vld_s3;
	assign pwr.addr = pos_s3;
	assign pwr.data = prod_s3;

	assign busy = iss_s1.vld | vld_s2 | vld_s3;

endmodule

[tb/haar_swt_multiscale_product_tb.sv]
// ----------------------------------------------------------------------------
// haar_swt_multiscale_product_tb
// Self-checking bench for the Haar SWT multiscale product block. Blocks of
// samples of many sizes are pushed, full and partial fetch runs follow, and
// each result word is checked against an in-bench transform of the block.
// Empty fetches, abandoned results and split loads are covered,
// with bursty input and patterned or random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haar_swt_multiscale_product_tb;

	import hswt_pkg::*;

	localparam int IDLE_LIMIT   = 20000;
	localparam int RANDOM_WORDS = 840;
	localparam longint unsigned PRODUCT_CAP = 64'd1 << 51;

	typedef struct {
		logic [RES_W-1:0] product;
		logic             last_res;
		logic             empty_res;
	} product_word_t;

	class detail_product_board;
		product_word_t   pending[$];
		longint          samples_held[BUF_WORDS];
		longint          approx_cur[BUF_WORDS];
		longint          approx_nxt[BUF_WORDS];
		longint unsigned prod_mag[BUF_WORDS];
		bit              prod_neg[BUF_WORDS];
		int              loaded;
		int              fetch_pos;
		bit              results_up;
		int              errors;
		int              checked;

		task report(string what, longint unsigned got, longint unsigned want);
			$display("mismatch at word %0d: %s got %0d, want %0d", checked, what, got, want);
			errors++;
		endtask

		function void scale_entry(int idx, longint d);
			longint unsigned m;
			m = (d < 0) ? longint'(-d) : longint'(d);
			if (d < 0)
				prod_neg[idx] = !prod_neg[idx];
			if (m == 0 || prod_mag[idx] == 0)
				prod_mag[idx] = 0;
			else if (m > PRODUCT_CAP / prod_mag[idx])
				prod_mag[idx] = PRODUCT_CAP;
			else begin
				prod_mag[idx] = prod_mag[idx] * m;
				if (prod_mag[idx] > PRODUCT_CAP)
					prod_mag[idx] = PRODUCT_CAP;
			end
		endfunction

		function void transform_block();
			int j;
			int nu;
			int levels;
			int s;
			longint x;
			longint y;
			j = 0;
			while ((2 << j) <= loaded)
				j++;
			nu = 1 << (j + 1);
			levels = (j < MAX_LEVELS) ? j : MAX_LEVELS;
			for (int o = 0; o < nu; o++)
				approx_cur[o] = (o < loaded) ? samples_held[o] : 0;
			for (int o = 0; o < loaded; o++) begin
				prod_mag[o] = 1;
				prod_neg[o] = 0;
			end
			for (int lv = 1; lv <= levels; lv++) begin
				s = 1 << (lv - 1);
				for (int o = 0; o < nu; o++) begin
					x = approx_cur[o];
					y = approx_cur[(o + s) & (nu - 1)];
					approx_nxt[o] = x + y;
					if (o < loaded)
						scale_entry(o, x - y);
				end
				for (int o = 0; o < nu; o++)
					approx_cur[o] = approx_nxt[o];
			end
		endfunction

		function void take_word(logic o, logic signed [SAMPLE_W-1:0] s, logic l);
			product_word_t w;
			if (o == OP_PUSH) begin
				if (results_up) begin
					results_up = 0;
					loaded = 0;
					fetch_pos = 0;
				end
				if (loaded < BUF_WORDS - 1) begin
					samples_held[loaded] = s;
					loaded++;
				end
				if (l) begin
					transform_block();
					fetch_pos = 0;
					results_up = 1;
				end
			end else begin
				if (!results_up) begin
					w.product = '0;
					w.last_res = 1'b0;
					w.empty_res = 1'b1;
				end else begin
					w.last_res = (fetch_pos + 1 >= loaded);
					w.empty_res = 1'b0;
					w.product = prod_neg[fetch_pos] ? '0 : prod_mag[fetch_pos][RES_W-1:0];
					fetch_pos++;
					if (w.last_res) begin
						results_up = 0;
						loaded = 0;
						fetch_pos = 0;
					end
				end
				pending.push_back(w);
			end
		endfunction

		task check_word(logic [RES_W-1:0] p, logic lr, logic er);
			product_word_t w;
			if (pending.size() == 0) begin
				report("unexpected word", 1, 0);
			end else begin
				w = pending.pop_front();
				if (p !== w.product)
					report("product", p, w.product);
				if (lr !== w.last_res)
					report("last_res", lr, w.last_res);
				if (er !== w.empty_res)
					report("empty_res", er, w.empty_res);
			end
			checked++;
		endtask
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic                       op;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;
	logic                       out_valid;
	logic                       out_ready;
	logic [RES_W-1:0]           product;
	logic                       last_res;
	logic                       empty_res;

	detail_product_board board;
	int burst_left;
	int sent_words;
	int idle_cycles;

	haar_swt_multiscale_product dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.sample    (sample),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.product   (product),
		.last_res  (last_res),
		.empty_res (empty_res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_word(input logic o, input logic signed [SAMPLE_W-1:0] s, input logic l);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
			                                        : $urandom_range(1, 30);
		end
		burst_left--;
		in_valid = 1'b1;
		op = o;
		sample = s;
		last = l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.take_word(o, s, l);
		sent_words++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(int mode, int i);
		case (mode)
			0: return SAMPLE_W'($urandom);
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'sh8000;
					1: return 16'sh7fff;
					2: return 16'shffff;
					default: return '0;
				endcase
			end
			2: return SAMPLE_W'($urandom_range(0, 32) - 16);
			default: return i[0] ? 16'sh8000 : 16'sh7fff;
		endcase
	endfunction

	task automatic push_run(input int n, input int mode, input bit close);
		for (int i = 0; i < n; i++)
			send_word(OP_PUSH, pick_sample(mode, i), close && (i == n - 1));
	endtask

	task automatic fetch_run(input int k);
		for (int i = 0; i < k; i++)
			send_word(OP_FETCH, SAMPLE_W'($urandom), 1'($urandom));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
	endtask

	// result side: stall on a changing pattern or at random, with stretches of no stall
	initial begin
		int span;
		int period;
		int mode;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			period = $urandom_range(2, 7);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = (k % period) != 0;
					2: out_ready = 1'($urandom_range(0, 1));
					default: out_ready = (k % period) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_word(product, last_res, empty_res);
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("haar_swt_multiscale_product_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int r;
		int a;
		int k;
		int mode;
		int stop_at;
		board = new;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_PUSH;
		sample = '0;
		last = 1'b0;
		burst_left = 0;
		sent_words = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fetch with nothing loaded, ignored fields set
		send_word(OP_FETCH, 16'sh8000, 1'b1);
		// single sample: no levels, product of nothing
		send_word(OP_PUSH, 16'sh7fff, 1'b1);
		fetch_run(2);
		send_word(OP_PUSH, 16'sh8000, 1'b0);
		send_word(OP_PUSH, 16'sh7fff, 1'b1);
		fetch_run(2);
		// partial fetch, then abandon with a new block
		send_word(OP_PUSH, 16'sh7fff, 1'b0);
		send_word(OP_PUSH, 16'sh8000, 1'b0);
		send_word(OP_PUSH, 16'sh7fff, 1'b1);
		fetch_run(1);
		push_run(4, 3, 1'b1);
		fetch_run(5);

		stop_at = sent_words + RANDOM_WORDS;
		while (sent_words < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				n = $urandom_range(1, 24);
			else if (r < 97)
				n = $urandom_range(25, 100);
			else
				n = $urandom_range(128, 300);
			mode = $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			if (r < 8)
				fetch_run($urandom_range(1, 3));
			if (r >= 8 && r < 16 && n > 1) begin
				// fetch in the middle of loading, then carry on
				k = $urandom_range(1, n - 1);
				push_run(k, mode, 1'b0);
				fetch_run(1);
				push_run(n - k, mode, 1'b1);
			end else begin
				push_run(n, mode, 1'b1);
			end
			a = $urandom_range(0, 9);
			if (a < 7)
				fetch_run(n + (($urandom_range(0, 3) == 0) ? 1 : 0));
			else if (a < 9)
				fetch_run($urandom_range(0, n - 1));
			else
				fetch_run(n + $urandom_range(1, 3));
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end

		// hold the input until all results are back, then one more block
		wait_drained();
		push_run(16, 0, 1'b1);
		fetch_run(16);

		@(negedge clk);
		in_valid = 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);
		if (board.pending.size() != 0)
			board.report("words outstanding", board.pending.size(), 0);
		if (board.errors == 0)
			$display("haar_swt_multiscale_product_tb: done, clean");
		else
			$display("haar_swt_multiscale_product_tb: done, errors");
		$finish;
	end

endmodule
